@@ src/allpass_delay_filter_macros.svh @@
// Assertion macros shared by the allpass delay filter modules.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ALLPASS_DELAY_FILTER_MACROS_SVH
`define ALLPASS_DELAY_FILTER_MACROS_SVH

// Checks that cons holds in the same cycle as ante, outside of reset.
`define APDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("apdf: same-cycle check failed");

// Checks that cons holds in the cycle after ante, outside of reset.
`define APDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("apdf: next-cycle check failed");

`endif

@@ src/apdf_pkg.sv @@
// Shared constants and the controller-to-datapath command type.
// Used by every module of the allpass delay filter; depends on nothing.
`default_nettype none

package apdf_pkg;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEFAULT       = 4096;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Fixed field widths of a request.
    localparam int DELAY_BITS = 12;
    localparam int COEFF_BITS = 16;
    localparam int GAIN_BITS  = 16;

    // Fraction bits of the coefficient (Q2.14) and of the gain (Q4.12).
    localparam int COEFF_FRAC = 14;
    localparam int GAIN_FRAC  = 12;

    // One strobe per datapath step; at most one is high in a cycle.
    typedef struct packed {
        logic load;    // capture the input request
        logic mult;    // form g*x and g*yd
        logic accum;   // sum, round and saturate y
        logic store;   // write x and y into the history memories, form y*gain
        logic fetch;   // read both histories at the delayed position
        logic finish;  // update the delayed values, pointer and output register
    } cmd_t;

endpackage

`default_nettype wire

@@ src/apdf_ram.sv @@
// Generic simple dual-port RAM: one write port and one registered read port.
// Used for the input and output history memories; depends on nothing.
`default_nettype none

module apdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/apdf_ctrl.sv @@
// Controller of the allpass delay filter: sequences the datapath steps per request.
// Depends on apdf_pkg and allpass_delay_filter_macros.svh.
`default_nettype none
`include "allpass_delay_filter_macros.svh"

module apdf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output apdf_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_ACCUM,
        ST_STORE,
        ST_FETCH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // The output register can take a new result once the old one is gone.
    // Requests are refused while reset is held.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Datapath strobes follow the state.
    always_comb begin
        cmd        = '0;
        cmd.load   = s_tready && s_tvalid;
        cmd.mult   = (state_reg == ST_MULT);
        cmd.accum  = (state_reg == ST_ACCUM);
        cmd.store  = (state_reg == ST_STORE);
        cmd.fetch  = (state_reg == ST_FETCH);
        cmd.finish = (state_reg == ST_FINISH) && out_free;
    end

    // Next state and output-valid logic.
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:  state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_STORE;
            ST_STORE: state_next = ST_FETCH;
            ST_FETCH: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // The history read always follows the history write.
    `APDF_ASSERT_NEXT(a_store_then_fetch, aclk, aresetn, cmd.store, cmd.fetch)
    // A finished step always presents a result on the next cycle.
    `APDF_ASSERT_NEXT(a_finish_shows_result, aclk, aresetn, cmd.finish, m_tvalid)
    // The datapath never gets two steps at once.
    `APDF_ASSERT_IMPLY(a_single_step, aclk, aresetn, 1'b1, ($onehot0(cmd)))

endmodule

`default_nettype wire

@@ src/apdf_datapath.sv @@
// Datapath of the allpass delay filter: multipliers, rounding, saturation,
// history memories and pointer. Depends on apdf_pkg, apdf_ram and the macros header.
`default_nettype none
`include "allpass_delay_filter_macros.svh"

module apdf_datapath #(
    parameter int DEPTH       = apdf_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = apdf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire apdf_pkg::cmd_t                         cmd,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample,
    input  wire logic        [apdf_pkg::DELAY_BITS-1:0] s_delay,
    input  wire logic signed [apdf_pkg::COEFF_BITS-1:0] s_coeff,
    input  wire logic signed [apdf_pkg::GAIN_BITS-1:0]  s_gain,
    output logic signed      [SAMPLE_BITS-1:0]          out_sample
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = (PW + 1 > apdf_pkg::DELAY_BITS) ? PW + 1 : apdf_pkg::DELAY_BITS;
    localparam int PB  = SAMPLE_BITS + apdf_pkg::COEFF_BITS;
    localparam int AW  = PB + 2;
    localparam int SW  = AW - apdf_pkg::COEFF_FRAC;
    localparam int GB  = SAMPLE_BITS + apdf_pkg::GAIN_BITS;
    localparam int OW  = GB + 1;
    localparam int OSW = OW - apdf_pkg::GAIN_FRAC;

    localparam logic [CW-1:0]        D_MAX   = CW'(DEPTH - 1);
    localparam logic [PW:0]          DEPTH_W = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0]        WP_LAST = PW'(DEPTH - 1);
    localparam logic signed [AW-1:0] ROUND_Y = AW'(2 ** (apdf_pkg::COEFF_FRAC - 1));
    localparam logic signed [OW-1:0] ROUND_O = OW'(2 ** (apdf_pkg::GAIN_FRAC - 1));

    // Request registers.
    logic signed [SAMPLE_BITS-1:0]          x_reg;
    logic        [PW-1:0]                   d_reg;
    logic signed [apdf_pkg::COEFF_BITS-1:0] g_reg;
    logic signed [apdf_pkg::GAIN_BITS-1:0]  gain_reg;

    // Filter state.
    logic signed [SAMPLE_BITS-1:0] xd_reg;
    logic signed [SAMPLE_BITS-1:0] yd_reg;
    logic        [PW-1:0]          wp_reg;
    logic                          wrapped_reg;
    logic                          hist_valid_reg;

    // Intermediate results.
    logic signed [PB-1:0]          p1_reg;
    logic signed [PB-1:0]          p2_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [GB-1:0]          p3_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic        [CW-1:0]          d_wide;
    logic        [PW-1:0]          d_clamp;
    logic signed [PB-1:0]          p1_next;
    logic signed [PB-1:0]          p2_next;
    logic signed [AW-1:0]          acc_sum;
    logic signed [SW-1:0]          y_wide;
    logic                          y_ovf;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic signed [GB-1:0]          p3_next;
    logic signed [OW-1:0]          o_sum;
    logic signed [OSW-1:0]         o_wide;
    logic                          o_ovf;
    logic signed [SAMPLE_BITS-1:0] out_next;
    logic        [PW:0]            rp_sum;
    logic        [PW-1:0]          rp;
    logic        [SAMPLE_BITS-1:0] rd_x;
    logic        [SAMPLE_BITS-1:0] rd_y;

    // Delays beyond the memory are clamped to its last entry.
    assign d_wide  = CW'(s_delay);
    assign d_clamp = (d_wide > D_MAX) ? D_MAX[PW-1:0] : d_wide[PW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= s_sample;
            d_reg    <= d_clamp;
            g_reg    <= s_coeff;
            gain_reg <= s_gain;
        end
    end

    // Feed-forward and feedback products.
    assign p1_next = PB'(g_reg) * PB'(x_reg);
    assign p2_next = PB'(g_reg) * PB'(yd_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // Sum in Q.29, round half up to Q.15 and saturate.
    assign acc_sum = AW'(p1_reg) + (AW'(xd_reg) <<< apdf_pkg::COEFF_FRAC)
                   - AW'(p2_reg) + ROUND_Y;
    assign y_wide  = acc_sum[AW-1:apdf_pkg::COEFF_FRAC];
    assign y_ovf   = !((&y_wide[SW-1:SAMPLE_BITS-1]) || !(|y_wide[SW-1:SAMPLE_BITS-1]));
    assign y_next  = y_ovf ? {y_wide[SW-1], {(SAMPLE_BITS-1){~y_wide[SW-1]}}}
                           : y_wide[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.accum) begin
            y_reg <= y_next;
        end
    end

    // Output gain product, formed while the histories are written.
    assign p3_next = GB'(y_reg) * GB'(gain_reg);

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            p3_reg <= p3_next;
        end
    end

    // Read position: pointer minus delay, modulo the depth.
    assign rp_sum = (PW + 1)'(wp_reg) + DEPTH_W - (PW + 1)'(d_reg);
    assign rp     = (d_reg <= wp_reg) ? (wp_reg - d_reg) : rp_sum[PW-1:0];

    apdf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_in_hist (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (wp_reg),
        .wr_data (x_reg),
        .rd_en   (cmd.fetch),
        .rd_addr (rp),
        .rd_data (rd_x)
    );

    apdf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_out_hist (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (wp_reg),
        .wr_data (y_reg),
        .rd_en   (cmd.fetch),
        .rd_addr (rp),
        .rd_data (rd_y)
    );

    // Output: round half up from Q.27 to Q.15 and saturate.
    assign o_sum    = OW'(p3_reg) + ROUND_O;
    assign o_wide   = o_sum[OW-1:apdf_pkg::GAIN_FRAC];
    assign o_ovf    = !((&o_wide[OSW-1:SAMPLE_BITS-1]) || !(|o_wide[OSW-1:SAMPLE_BITS-1]));
    assign out_next = o_ovf ? {o_wide[OSW-1], {(SAMPLE_BITS-1){~o_wide[OSW-1]}}}
                            : o_wide[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    assign out_sample = out_reg;

    // Memories fill from entry zero upward, so an entry has been written once the
    // pointer has wrapped or it lies at or below the pointer; other entries read zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xd_reg         <= '0;
            yd_reg         <= '0;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            hist_valid_reg <= 1'b0;
        end else begin
            if (cmd.fetch) begin
                hist_valid_reg <= wrapped_reg || (rp <= wp_reg);
            end
            if (cmd.finish) begin
                xd_reg <= hist_valid_reg ? $signed(rd_x) : '0;
                yd_reg <= hist_valid_reg ? $signed(rd_y) : '0;
                if (wp_reg == WP_LAST) begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
        end
    end

    // Every finished sample moves the shared pointer.
    `APDF_ASSERT_NEXT(a_pointer_moves, aclk, aresetn, cmd.finish, (wp_reg != $past(wp_reg)))

endmodule

`default_nettype wire

@@ src/allpass_delay_filter.sv @@
// Schroeder allpass filter with per-sample delay, coefficient and output gain.
//
// Requests arrive on the s_ stream channel, one audio sample with its delay,
// coefficient g (Q2.14) and gain (Q4.12) per request. Each request gives exactly
// one result on the m_ channel: the filtered sample y = g*x + xd - g*yd, times
// the gain, rounded and saturated. The delayed values come from two circular
// history memories of DEPTH entries that share one write pointer; the effective
// delay is delay_length + 1, with delay_length clamped to DEPTH - 1.
// Each request passes through the controller's sequence of multiply, accumulate,
// history write, history read and update steps, and the result is registered at the
// update step; the next request is taken only after the update step, back in idle.
// A new request is taken while the previous result still waits on m_; if the
// receiver stalls longer, the block holds in its last step until the output
// register frees up, and s_tready stays low meanwhile.
// Reset (aresetn low, synchronous) clears the pointer, delayed values and valid;
// history entries not yet written read as zero, so no clearing pass is needed.
`default_nettype none

module allpass_delay_filter #(
    parameter int DEPTH       = apdf_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = apdf_pkg::SAMPLE_BITS_DEFAULT,
    localparam int IN_BITS    = SAMPLE_BITS + apdf_pkg::DELAY_BITS
                              + apdf_pkg::COEFF_BITS + apdf_pkg::GAIN_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // From bit 0 up: sample_in, delay_length, coeff, gain, zero padding.
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // From bit 0 up: sample_out, zero padding.
    output logic      [OUT_W-1:0] m_tdata
);

    localparam int D_LO = SAMPLE_BITS;
    localparam int C_LO = D_LO + apdf_pkg::DELAY_BITS;
    localparam int G_LO = C_LO + apdf_pkg::COEFF_BITS;

    apdf_pkg::cmd_t                cmd;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    // Unpack the request fields.
    logic signed [SAMPLE_BITS-1:0]          sample_in;
    logic        [apdf_pkg::DELAY_BITS-1:0] delay_length;
    logic signed [apdf_pkg::COEFF_BITS-1:0] coeff;
    logic signed [apdf_pkg::GAIN_BITS-1:0]  gain;

    assign sample_in    = s_tdata[D_LO-1:0];
    assign delay_length = s_tdata[C_LO-1:D_LO];
    assign coeff        = s_tdata[G_LO-1:C_LO];
    assign gain         = s_tdata[IN_BITS-1:G_LO];

    apdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    apdf_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_sample   (sample_in),
        .s_delay    (delay_length),
        .s_coeff    (coeff),
        .s_gain     (gain),
        .out_sample (sample_out)
    );

    // Pack the result, zero-filled to whole bytes.
    assign m_tdata = OUT_W'($unsigned(sample_out));

endmodule

`default_nettype wire
